// ===== sv/ldob_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Order book package
// Shared widths, side codes and the types that pass between the front end,
// the queue, the sequencer and the two level tables.
// ----------------------------------------------------------------------------
package ldob_pkg;

   localparam int DEPTH    = 5;
   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int PRICE_W  = 32;
   localparam int RAW_W    = 32;
   localparam int SIZE_W   = 31;
   localparam int SYM_W    = 16;
   localparam int TS_W     = 64;
   localparam int SIDE_W   = 2;
   localparam int QDEPTH   = 2;
   localparam int QPTR_W   = $clog2(QDEPTH);
   localparam int QCNT_W   = $clog2(QDEPTH + 1);

   localparam logic [SIDE_W-1:0] SIDE_BID = 2'd0;
   localparam logic [SIDE_W-1:0] SIDE_ASK = 2'd1;

   // One classified update, as it waits in the queue.
   typedef struct packed {
      logic               tgt_bid;
      logic               tgt_ask;
      logic               add;
      logic [PRICE_W-1:0] price;
      logic [SIZE_W-1:0]  size;
      logic [SYM_W-1:0]   symbol_id;
      logic [TS_W-1:0]    timestamp;
   } op_type;

   // Commands from the sequencer to a level table.
   typedef struct packed {
      logic cmp;
      logic apply;
   } tbl_cmd_type;

   // Best level of a table as it stands after the pending update.
   typedef struct packed {
      logic               nonempty;
      logic [PRICE_W-1:0] price;
      logic [SIZE_W-1:0]  size;
   } tbl_head_type;

   typedef enum logic [1:0] {
      ST_LOAD  = 2'b01,
      ST_APPLY = 2'b10
   } back_state_type;

endpackage
`default_nettype wire

// ===== sv/limited_depth_order_book_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Limited-depth order book core
// Keeps the top DEPTH bid and ask levels and reports the top of book.
// ----------------------------------------------------------------------------
// Usage:
// The req_ channel takes one price-level update per item: side (bid, ask,
// or any other code, which leaves the book unchanged), price in ticks, a
// signed size where a positive value inserts or overwrites the level and a
// zero or negative value deletes it, plus a symbol id and a timestamp that
// are passed through. After each item, if both sides hold at least one
// level, one item appears on the rsp_ channel with the best bid and best ask
// price and size; otherwise the update produces no result.
// The front end classifies each item and places it in a two-entry queue.
// The sequencer then spends two steps on each item: one to compare the price
// against every level cell of both tables, one to shift the cells of the
// selected table and load the result register. The next item is popped
// only once the apply step of the current one is done.
// A stalled rsp_ready holds the result register; the sequencer waits in
// its apply step, while the queue keeps taking items until it is full.
// Synchronous reset empties both tables and the queue; no clearing pass.
// ----------------------------------------------------------------------------
module limited_depth_order_book_core import ldob_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [SIDE_W-1:0]  req_side,
   input  wire logic [PRICE_W-1:0] req_price,
   input  wire logic [RAW_W-1:0]   req_size,
   input  wire logic [SYM_W-1:0]   req_symbol_id,
   input  wire logic [TS_W-1:0]    req_timestamp,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [SYM_W-1:0]        rsp_symbol_id_out,
   output logic [PRICE_W-1:0]      rsp_best_bid_price,
   output logic [SIZE_W-1:0]       rsp_best_bid_size,
   output logic [PRICE_W-1:0]      rsp_best_ask_price,
   output logic [SIZE_W-1:0]       rsp_best_ask_size,
   output logic [TS_W-1:0]         rsp_timestamp_out
);

   logic   q_full, q_push, q_pop, q_not_empty;
   op_type q_push_op, q_head;

   // Front end: decode side and action, push into the queue.
   ldob_front u_front (
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_side     (req_side),
      .req_price    (req_price),
      .req_size     (req_size),
      .req_symbol_id(req_symbol_id),
      .req_timestamp(req_timestamp),
      .q_full       (q_full),
      .push         (q_push),
      .push_op      (q_push_op)
   );

   // Queue that lets the front end keep accepting while the back end stalls.
   ldob_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_op  (q_push_op),
      .full     (q_full),
      .pop      (q_pop),
      .not_empty(q_not_empty),
      .head_op  (q_head)
   );

   // Back end: table update sequencer and the result register.
   ldob_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_not_empty       (q_not_empty),
      .q_head            (q_head),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_symbol_id_out (rsp_symbol_id_out),
      .rsp_best_bid_price(rsp_best_bid_price),
      .rsp_best_bid_size (rsp_best_bid_size),
      .rsp_best_ask_price(rsp_best_ask_price),
      .rsp_best_ask_size (rsp_best_ask_size),
      .rsp_timestamp_out (rsp_timestamp_out)
   );

endmodule
`default_nettype wire

// ===== sv/ldob_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Update queue
// A short first-in first-out queue that decouples the classifying front end
// from the table sequencer.
// ----------------------------------------------------------------------------
module ldob_queue import ldob_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   push,
   input  wire op_type push_op,
   output logic        full,
   input  wire logic   pop,
   output logic        not_empty,
   output op_type      head_op
);

   op_type             mem_ff [QDEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  cnt_ff, cnt_in;

   function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
      if (p == QPTR_W'(QDEPTH - 1)) begin
         return '0;
      end
      return p + QPTR_W'(1);
   endfunction

   always_comb begin
      full      = (cnt_ff == QCNT_W'(QDEPTH));
      not_empty = (cnt_ff != '0);
      head_op   = mem_ff[rd_ptr_ff];
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule
`default_nettype wire

// ===== sv/ldob_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Update front end
// Accepts raw updates, decodes the side and the insert or delete action,
// and pushes the classified item into the queue.
// ----------------------------------------------------------------------------
module ldob_front import ldob_pkg::*; (
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [SIDE_W-1:0]  req_side,
   input  wire logic [PRICE_W-1:0] req_price,
   input  wire logic [RAW_W-1:0]   req_size,
   input  wire logic [SYM_W-1:0]   req_symbol_id,
   input  wire logic [TS_W-1:0]    req_timestamp,
   input  wire logic               q_full,
   output logic                    push,
   output op_type                  push_op
);

   always_comb begin
      req_ready         = !q_full;
      push              = req_valid && !q_full;
      push_op.tgt_bid   = (req_side == SIDE_BID);
      push_op.tgt_ask   = (req_side == SIDE_ASK);
      // A strictly positive size inserts or overwrites; anything else deletes.
      push_op.add       = (req_size != '0) && !req_size[RAW_W-1];
      push_op.price     = req_price;
      push_op.size      = req_size[SIZE_W-1:0];
      push_op.symbol_id = req_symbol_id;
      push_op.timestamp = req_timestamp;
   end

endmodule
`default_nettype wire

// ===== sv/ldob_table.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Level table
// One side of the book: a sorted row of DEPTH level cells. A compare step
// registers per-cell match and position flags; apply shifts or rewrites cells.
// ----------------------------------------------------------------------------
module ldob_table import ldob_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        high_first,
   input  wire tbl_cmd_type cmd,
   input  wire op_type      cmp_op,
   output tbl_head_type     head_next
);

   logic [PRICE_W-1:0] price_ff [DEPTH];
   logic [PRICE_W-1:0] price_in [DEPTH];
   logic [SIZE_W-1:0]  size_ff  [DEPTH];
   logic [SIZE_W-1:0]  size_in  [DEPTH];
   logic [CNT_W-1:0]   count_ff, count_in;

   logic [DEPTH-1:0]   valid;
   logic [DEPTH-1:0]   match_ff, match_in;
   logic [DEPTH-1:0]   take_ff, take_in;
   logic [DEPTH-1:0]   delsh_ff, delsh_in;
   logic               sel_ff, add_ff;
   logic [PRICE_W-1:0] new_price_ff;
   logic [SIZE_W-1:0]  new_size_ff;
   logic               found;

   // Per-cell flags. Because the row is sorted, the cells the new price ranks
   // before, and the cells at or after a matching price, each form a suffix.
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         valid[i]    = (CNT_W'(i) < count_ff);
         match_in[i] = valid[i] && (price_ff[i] == cmp_op.price);
         take_in[i]  = !valid[i] ||
                       (high_first ? (cmp_op.price > price_ff[i])
                                   : (cmp_op.price < price_ff[i]));
         delsh_in[i] = valid[i] &&
                       (high_first ? (cmp_op.price >= price_ff[i])
                                   : (cmp_op.price <= price_ff[i]));
      end
   end

   always_comb begin
      found    = |match_ff;
      count_in = count_ff;
      for (int i = 0; i < DEPTH; i++) begin
         price_in[i] = price_ff[i];
         size_in[i]  = size_ff[i];
      end
      if (cmd.apply && sel_ff) begin
         if (add_ff && found) begin
            for (int i = 0; i < DEPTH; i++) begin
               if (match_ff[i]) begin
                  size_in[i] = new_size_ff;
               end
            end
         end else if (add_ff) begin
            if (take_ff[0]) begin
               price_in[0] = new_price_ff;
               size_in[0]  = new_size_ff;
            end
            for (int i = 1; i < DEPTH; i++) begin
               if (take_ff[i-1]) begin
                  price_in[i] = price_ff[i-1];
                  size_in[i]  = size_ff[i-1];
               end else if (take_ff[i]) begin
                  price_in[i] = new_price_ff;
                  size_in[i]  = new_size_ff;
               end
            end
            // A full table keeps its count; the worst level falls off the end.
            if (count_ff != CNT_W'(DEPTH)) begin
               count_in = count_ff + CNT_W'(1);
            end
         end else if (found) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
               if (delsh_ff[i]) begin
                  price_in[i] = price_ff[i+1];
                  size_in[i]  = size_ff[i+1];
               end
            end
            count_in = count_ff - CNT_W'(1);
         end
      end
      head_next.nonempty = (count_in != '0);
      head_next.price    = price_in[0];
      head_next.size     = size_in[0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         match_ff <= '0;
         take_ff  <= '0;
         delsh_ff <= '0;
         sel_ff   <= 1'b0;
         add_ff   <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (cmd.cmp) begin
            match_ff <= match_in;
            take_ff  <= take_in;
            delsh_ff <= delsh_in;
            sel_ff   <= high_first ? cmp_op.tgt_bid : cmp_op.tgt_ask;
            add_ff   <= cmp_op.add;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         price_ff[i] <= price_in[i];
         size_ff[i]  <= size_in[i];
      end
      if (cmd.cmp) begin
         new_price_ff <= cmp_op.price;
         new_size_ff  <= cmp_op.size;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("level count exceeds table depth");

   a_match_unique: assert property (@(posedge clock) disable iff (reset)
      $onehot0(match_ff))
      else $error("price matches more than one level");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (cmd.apply && sel_ff && add_ff && !found && count_ff != CNT_W'(DEPTH))
      |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("insert into a non-full table did not add a level");

   a_delete_shrinks: assert property (@(posedge clock) disable iff (reset)
      (cmd.apply && sel_ff && !add_ff && found)
      |=> (count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("delete of a present level did not remove it");

endmodule
`default_nettype wire

// ===== sv/ldob_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Book sequencer
// Pops one classified item, runs the compare and apply steps on both level
// tables, and when both have a level loads the top-of-book output register.
// ----------------------------------------------------------------------------
module ldob_back import ldob_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          q_not_empty,
   input  wire op_type        q_head,
   output logic               q_pop,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output logic [SYM_W-1:0]   rsp_symbol_id_out,
   output logic [PRICE_W-1:0] rsp_best_bid_price,
   output logic [SIZE_W-1:0]  rsp_best_bid_size,
   output logic [PRICE_W-1:0] rsp_best_ask_price,
   output logic [SIZE_W-1:0]  rsp_best_ask_size,
   output logic [TS_W-1:0]    rsp_timestamp_out
);

   back_state_type     st_ff, st_in;
   tbl_cmd_type        cmd;
   tbl_head_type       bid_head, ask_head;
   logic               out_free, emit;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [SYM_W-1:0]   sym_ff;
   logic [TS_W-1:0]    ts_ff;
   logic [SYM_W-1:0]   out_sym_ff;
   logic [PRICE_W-1:0] out_bid_price_ff, out_ask_price_ff;
   logic [SIZE_W-1:0]  out_bid_size_ff, out_ask_size_ff;
   logic [TS_W-1:0]    out_ts_ff;

   ldob_table u_bid (
      .clock     (clock),
      .reset     (reset),
      .high_first(1'b1),
      .cmd       (cmd),
      .cmp_op    (q_head),
      .head_next (bid_head)
   );

   ldob_table u_ask (
      .clock     (clock),
      .reset     (reset),
      .high_first(1'b0),
      .cmd       (cmd),
      .cmp_op    (q_head),
      .head_next (ask_head)
   );

   always_comb begin
      out_free  = !rsp_valid_ff || rsp_ready;
      q_pop     = (st_ff == ST_LOAD) && q_not_empty;
      cmd.cmp   = q_pop;
      cmd.apply = (st_ff == ST_APPLY) && out_free;
      emit      = bid_head.nonempty && ask_head.nonempty;
      st_in     = st_ff;
      unique case (st_ff)
         ST_LOAD: begin
            if (q_pop) begin
               st_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            if (cmd.apply) begin
               st_in = ST_LOAD;
            end
         end
         default: begin
            st_in = ST_LOAD;
         end
      endcase
      if (cmd.apply) begin
         rsp_valid_in = emit;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_LOAD;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         sym_ff <= q_head.symbol_id;
         ts_ff  <= q_head.timestamp;
      end
      if (cmd.apply && emit) begin
         out_sym_ff       <= sym_ff;
         out_bid_price_ff <= bid_head.price;
         out_bid_size_ff  <= bid_head.size;
         out_ask_price_ff <= ask_head.price;
         out_ask_size_ff  <= ask_head.size;
         out_ts_ff        <= ts_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_symbol_id_out  = out_sym_ff;
   assign rsp_best_bid_price = out_bid_price_ff;
   assign rsp_best_bid_size  = out_bid_size_ff;
   assign rsp_best_ask_price = out_ask_price_ff;
   assign rsp_best_ask_size  = out_ask_size_ff;
   assign rsp_timestamp_out  = out_ts_ff;

   a_apply_waits: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_APPLY && !out_free) |=> (st_ff == ST_APPLY))
      else $error("apply step left while the result register was blocked");

   a_no_pop_busy: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> (st_ff == ST_APPLY))
      else $error("popped item did not reach the apply step");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> rsp_valid_ff)
      else $error("pending result dropped while stalled");

endmodule
`default_nettype wire

// ===== verif/limited_depth_order_book_core_test.sv =====
// ----------------------------------------------------------------------------
// Order book core testbench
// Drives price-level updates into limited_depth_order_book_core, keeps its
// own copy of the bid and ask level tables to predict every top-of-book item,
// and checks each item the core emits against the oldest prediction. Named
// test tasks cover directed corner cases, random traffic under several idle
// and stall mixes, a long receiver hold-off and a sender pause.
// ----------------------------------------------------------------------------
module limited_depth_order_book_core_test;
   import ldob_pkg::*;

   // Timing of the run. The core registers each result in its apply step,
   // so the settle wait after a drain still sees any stray result.
   localparam int CLK_HALF       = 10;
   localparam int RESET_CYCLES   = 4;
   localparam int SETTLE_CYCLES  = 6;
   localparam int TIMEOUT_CYCLES = 400000;
   localparam int MAX_SHOWN      = 10;

   // Index of each table in the predictor's arrays.
   localparam int BID_BOOK = 0;
   localparam int ASK_BOOK = 1;

   // Side codes that the core must ignore.
   localparam logic [SIDE_W-1:0] SIDE_OTHER_LO = 2'd2;
   localparam logic [SIDE_W-1:0] SIDE_OTHER_HI = 2'd3;

   // Random prices mostly come from a small pool, so that overwrites and
   // deletes of present levels happen often.
   localparam logic [PRICE_W-1:0] POOL_BASE = 32'd100000;
   localparam int                 POOL_SPAN = 11;

   localparam logic [PRICE_W-1:0] PRICE_MAX = '1;
   localparam logic [RAW_W-1:0]   SIZE_MAX  = 32'h7FFF_FFFF;
   localparam logic [RAW_W-1:0]   SIZE_MIN  = 32'h8000_0000;
   localparam logic [RAW_W-1:0]   SIZE_NEG1 = 32'hFFFF_FFFF;

   // One top-of-book item as the core should emit it.
   typedef struct packed {
      logic [SYM_W-1:0]   symbol_id;
      logic [PRICE_W-1:0] bid_price;
      logic [SIZE_W-1:0]  bid_size;
      logic [PRICE_W-1:0] ask_price;
      logic [SIZE_W-1:0]  ask_size;
      logic [TS_W-1:0]    timestamp;
   } top_of_book_type;

   // Every input starts at a known value.
   logic               clock         = 1'b0;
   logic               reset         = 1'b1;
   logic               req_valid     = 1'b0;
   logic [SIDE_W-1:0]  req_side      = '0;
   logic [PRICE_W-1:0] req_price     = '0;
   logic [RAW_W-1:0]   req_size      = '0;
   logic [SYM_W-1:0]   req_symbol_id = '0;
   logic [TS_W-1:0]    req_timestamp = '0;
   logic               rsp_ready     = 1'b0;

   logic               req_ready;
   logic               rsp_valid;
   logic [SYM_W-1:0]   rsp_symbol_id_out;
   logic [PRICE_W-1:0] rsp_best_bid_price;
   logic [SIZE_W-1:0]  rsp_best_bid_size;
   logic [PRICE_W-1:0] rsp_best_ask_price;
   logic [SIZE_W-1:0]  rsp_best_ask_size;
   logic [TS_W-1:0]    rsp_timestamp_out;

   // Predicted level tables. Each side keeps one spare entry, because an
   // insert into a full table briefly holds DEPTH + 1 levels.
   logic [PRICE_W-1:0] level_price [0:1][0:DEPTH];
   logic [SIZE_W-1:0]  level_size  [0:1][0:DEPTH];
   int                 level_count [0:1];

   top_of_book_type    tob_expected[$];

   // Knobs shared between the test tasks and the result receiver.
   int tx_idle_pct  = 0;
   int rx_stall_pct = 0;
   int rx_hold_left = 0;

   int mismatch_count = 0;
   int orphan_count   = 0;
   int shown_count    = 0;

   limited_depth_order_book_core uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_side           (req_side),
      .req_price          (req_price),
      .req_size           (req_size),
      .req_symbol_id      (req_symbol_id),
      .req_timestamp      (req_timestamp),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_symbol_id_out  (rsp_symbol_id_out),
      .rsp_best_bid_price (rsp_best_bid_price),
      .rsp_best_bid_size  (rsp_best_bid_size),
      .rsp_best_ask_price (rsp_best_ask_price),
      .rsp_best_ask_size  (rsp_best_ask_size),
      .rsp_timestamp_out  (rsp_timestamp_out)
   );

   initial begin
      forever begin
         #(CLK_HALF) clock = ~clock;
      end
   end

   // Bids rank highest price first, asks lowest price first.
   function automatic bit outranks(input int book, input logic [PRICE_W-1:0] a,
                                   input logic [PRICE_W-1:0] b);
      return (book == BID_BOOK) ? (a > b) : (a < b);
   endfunction

   // Applies one update to one predicted table: a delete removes the level
   // if present, an insert overwrites a present level or places a new one in
   // rank order and then drops the worst level if the table overflows.
   function automatic void apply_level_update(input int book,
                                              input logic [PRICE_W-1:0] px,
                                              input logic [SIZE_W-1:0] sz,
                                              input bit add);
      int i;
      int pos;
      i = 0;
      while (i < level_count[book] && level_price[book][i] != px)
         i++;
      if (!add) begin
         if (i < level_count[book]) begin
            for (; i + 1 < level_count[book]; i++) begin
               level_price[book][i] = level_price[book][i+1];
               level_size[book][i]  = level_size[book][i+1];
            end
            level_count[book]--;
         end
         return;
      end
      if (i < level_count[book]) begin
         level_size[book][i] = sz;
         return;
      end
      pos = level_count[book];
      for (i = 0; i < level_count[book]; i++) begin
         if (outranks(book, px, level_price[book][i])) begin
            pos = i;
            break;
         end
      end
      for (i = level_count[book]; i > pos; i--) begin
         level_price[book][i] = level_price[book][i-1];
         level_size[book][i]  = level_size[book][i-1];
      end
      level_price[book][pos] = px;
      level_size[book][pos]  = sz;
      level_count[book]++;
      if (level_count[book] > DEPTH)
         level_count[book] = DEPTH;
   endfunction

   // Works out the effect of one accepted update and queues the top-of-book
   // item it should produce. A size with the sign bit set, or zero, deletes.
   function automatic void predict_top_of_book(input logic [SIDE_W-1:0] side,
                                               input logic [PRICE_W-1:0] px,
                                               input logic [RAW_W-1:0] raw,
                                               input logic [SYM_W-1:0] sym,
                                               input logic [TS_W-1:0] ts);
      top_of_book_type tob;
      bit add;
      add = (raw != '0) && !raw[RAW_W-1];
      if (side == SIDE_BID)
         apply_level_update(BID_BOOK, px, raw[SIZE_W-1:0], add);
      else if (side == SIDE_ASK)
         apply_level_update(ASK_BOOK, px, raw[SIZE_W-1:0], add);
      if (level_count[BID_BOOK] == 0 || level_count[ASK_BOOK] == 0)
         return;
      tob.symbol_id = sym;
      tob.bid_price = level_price[BID_BOOK][0];
      tob.bid_size  = level_size[BID_BOOK][0];
      tob.ask_price = level_price[ASK_BOOK][0];
      tob.ask_size  = level_size[ASK_BOOK][0];
      tob.timestamp = ts;
      tob_expected.push_back(tob);
   endfunction

   // Watches both channels on every edge. Inputs are predicted before the
   // result side is checked, so one process sees both in a fixed order and
   // the values read are those that stood just before the edge.
   always @(posedge clock) begin
      top_of_book_type want;
      if (!reset) begin
         if (req_valid && req_ready)
            predict_top_of_book(req_side, req_price, req_size, req_symbol_id,
                                req_timestamp);
         if (rsp_valid && rsp_ready) begin
            if (tob_expected.size() == 0) begin
               orphan_count++;
               if (shown_count < MAX_SHOWN) begin
                  shown_count++;
                  $display("unexpected result: sym=%h bid=%h/%h ask=%h/%h ts=%h",
                           rsp_symbol_id_out, rsp_best_bid_price, rsp_best_bid_size,
                           rsp_best_ask_price, rsp_best_ask_size, rsp_timestamp_out);
               end
            end else begin
               want = tob_expected.pop_front();
               if (rsp_symbol_id_out  !== want.symbol_id ||
                   rsp_best_bid_price !== want.bid_price ||
                   rsp_best_bid_size  !== want.bid_size  ||
                   rsp_best_ask_price !== want.ask_price ||
                   rsp_best_ask_size  !== want.ask_size  ||
                   rsp_timestamp_out  !== want.timestamp) begin
                  mismatch_count++;
                  if (shown_count < MAX_SHOWN) begin
                     shown_count++;
                     $display("mismatch: expected sym=%h bid=%h/%h ask=%h/%h ts=%h",
                              want.symbol_id, want.bid_price, want.bid_size,
                              want.ask_price, want.ask_size, want.timestamp);
                     $display("          actual   sym=%h bid=%h/%h ask=%h/%h ts=%h",
                              rsp_symbol_id_out, rsp_best_bid_price, rsp_best_bid_size,
                              rsp_best_ask_price, rsp_best_ask_size, rsp_timestamp_out);
                  end
               end
            end
         end
      end
   end

   // Result receiver. A long hold-off, when requested, is counted down here
   // one cycle at a time; otherwise ready follows the current stall rate.
   always @(posedge clock) begin
      if (rx_hold_left > 0) begin
         rsp_ready <= 1'b0;
         rx_hold_left = rx_hold_left - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rx_stall_pct);
      end
   end

   // Offers one update and returns after an edge once req_ready reads high.
   // Valid is only lowered during an idle gap, so back-to-back items never
   // lower and raise it in the same step.
   task automatic send_update(input logic [SIDE_W-1:0] side,
                              input logic [PRICE_W-1:0] px,
                              input logic [RAW_W-1:0] raw,
                              input logic [SYM_W-1:0] sym,
                              input logic [TS_W-1:0] ts);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_side      <= side;
      req_price     <= px;
      req_size      <= raw;
      req_symbol_id <= sym;
      req_timestamp <= ts;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
   endtask

   // Stops offering, waits for every predicted item to arrive and then
   // lets the core settle so that a late extra result would still be seen.
   task automatic drain_book_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tob_expected.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Field extremes, the ignored side codes, overwrite, delete of an absent
   // price, delete by zero, by the most negative size and by minus one, an
   // insert worse than a full table, an insert that pushes out the worst
   // level, and an emptied side that silences the output.
   task automatic run_directed_cases();
      tx_idle_pct  = 0;
      rx_stall_pct = 0;
      // Bids alone give no result; the first ask opens the output.
      send_update(SIDE_BID, 32'd100, 32'd10, 16'h0000, 64'h0);
      send_update(SIDE_ASK, 32'd200, 32'd20, 16'h0001, 64'h1);
      // The other side codes still report, with both tables untouched.
      send_update(SIDE_OTHER_LO, '0, 32'd5, 16'h0002, 64'h2);
      send_update(SIDE_OTHER_HI, PRICE_MAX, SIZE_NEG1, 16'h0003, 64'h3);
      send_update(SIDE_BID, PRICE_MAX, SIZE_MAX, 16'hFFFF, '1);
      send_update(SIDE_ASK, '0, SIZE_MAX, 16'hA5A5, 64'h5A5A_5A5A_5A5A_5A5A);
      send_update(SIDE_BID, PRICE_MAX, 32'd3, 16'h0006, 64'h6);
      send_update(SIDE_BID, 32'd50, 32'd0, 16'h0007, 64'h7);
      // Fill the bid table, then try a level below the worst one.
      send_update(SIDE_BID, 32'd90, 32'd9, 16'h0008, 64'h8);
      send_update(SIDE_BID, 32'd80, 32'd8, 16'h0009, 64'h9);
      send_update(SIDE_BID, 32'd70, 32'd7, 16'h000A, 64'hA);
      send_update(SIDE_BID, 32'd10, 32'd1, 16'h000B, 64'hB);
      send_update(SIDE_BID, 32'd95, 32'd2, 16'h000C, 64'hC);
      send_update(SIDE_BID, PRICE_MAX, SIZE_MIN, 16'h000D, 64'hD);
      send_update(SIDE_ASK, '0, SIZE_NEG1, 16'h000E, 64'hE);
      // Emptying the ask side stops the output until an ask returns.
      send_update(SIDE_ASK, 32'd200, 32'd0, 16'h000F, 64'hF);
      send_update(SIDE_OTHER_LO, 32'd1, 32'd1, 16'h0010, 64'h10);
      send_update(SIDE_ASK, 32'd300, 32'd30, 16'h0011, 64'h11);
      send_update(SIDE_ASK, PRICE_MAX, 32'd1, 16'h0012, 64'h12);
      drain_book_results();
   endtask

   // Random updates: mostly pool prices so that levels are hit again, a
   // share of full-range and extreme prices, and a mix of insert sizes and
   // delete sizes across the whole signed range.
   task automatic run_random_phase(input int n_items, input int idle_pct,
                                   input int stall_pct);
      logic [SIDE_W-1:0]  side;
      logic [PRICE_W-1:0] px;
      logic [RAW_W-1:0]   raw;
      int                 roll;
      tx_idle_pct  = idle_pct;
      rx_stall_pct = stall_pct;
      for (int k = 0; k < n_items; k++) begin
         roll = $urandom_range(99);
         if (roll < 46)
            side = SIDE_BID;
         else if (roll < 92)
            side = SIDE_ASK;
         else
            side = ($urandom_range(1) != 0) ? SIDE_OTHER_HI : SIDE_OTHER_LO;
         roll = $urandom_range(99);
         if (roll < 70)
            px = POOL_BASE + $urandom_range(POOL_SPAN);
         else if (roll < 88)
            px = $urandom;
         else if (roll < 94)
            px = '0;
         else
            px = PRICE_MAX;
         roll = $urandom_range(99);
         if (roll < 50)
            raw = $urandom_range(1, 5000);
         else if (roll < 72)
            raw = $urandom_range(1, SIZE_MAX);
         else if (roll < 86)
            raw = '0;
         else
            raw = {1'b1, 31'($urandom)};
         send_update(side, px, raw, 16'($urandom), {$urandom, $urandom});
      end
      drain_book_results();
   endtask

   // The receiver holds off for a long stretch while the sender keeps
   // offering, so the core's queue fills and it has to drop req_ready.
   task automatic run_backpressure_burst();
      tx_idle_pct  = 0;
      rx_stall_pct = 0;
      rx_hold_left = 80;
      for (int k = 0; k < 24; k++) begin
         send_update((k % 2 == 0) ? SIDE_BID : SIDE_ASK,
                     POOL_BASE + $urandom_range(POOL_SPAN),
                     $urandom_range(1, 5000), 16'($urandom), {$urandom, $urandom});
      end
      drain_book_results();
   endtask

   // The sender stops until every expected item is in, then resumes.
   task automatic run_sender_pause();
      tx_idle_pct  = 0;
      rx_stall_pct = 50;
      for (int k = 0; k < 6; k++) begin
         send_update(SIDE_ASK, POOL_BASE + $urandom_range(POOL_SPAN),
                     $urandom_range(1, 5000), 16'($urandom), {$urandom, $urandom});
      end
      drain_book_results();
      for (int k = 0; k < 6; k++) begin
         send_update(SIDE_BID, POOL_BASE + $urandom_range(POOL_SPAN),
                     (k % 3 == 0) ? '0 : $urandom_range(1, 5000),
                     16'($urandom), {$urandom, $urandom});
      end
      drain_book_results();
   endtask

   initial begin
      level_count[BID_BOOK] = 0;
      level_count[ASK_BOOK] = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      run_directed_cases();
      run_random_phase(130, 0, 0);
      run_random_phase(125, 75, 0);
      run_random_phase(125, 0, 75);
      run_random_phase(125, 11, 11);
      run_backpressure_burst();
      run_sender_pause();

      drain_book_results();
      if (mismatch_count == 0 && orphan_count == 0 && tob_expected.size() == 0)
         $display("limited_depth_order_book_core_test: clean");
      else
         $display("limited_depth_order_book_core_test: errors");
      $finish;
   end

   // Watchdog: far beyond the slowest correct run of this stimulus.
   initial begin
      #(TIMEOUT_CYCLES * 2 * CLK_HALF);
      $display("limited_depth_order_book_core_test: errors");
      $finish;
   end

endmodule

// ===== sim.f =====
sv/ldob_pkg.sv
sv/ldob_queue.sv
sv/ldob_front.sv
sv/ldob_table.sv
sv/ldob_back.sv
sv/limited_depth_order_book_core.sv
verif/limited_depth_order_book_core_test.sv
